// File: hdl/pdi_pkg.sv
package pdi_pkg;

  // Event codes carried in the kind field
  typedef enum logic [2:0] {
    KindScan         = 3'd0,
    KindSwitch       = 3'd1,
    KindTick         = 3'd2,
    KindRemoteLock   = 3'd3,
    KindRemoteUnlock = 3'd4,
    KindRemoteOpen   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    LockNone   = 2'd0,
    LockSwitch = 2'd1,
    LockRemote = 2'd2,
    LockBoth   = 2'd3
  } lock_e;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 1'b0,
    CfgHold      = 1'b1
  } cfg_idx_e;

  localparam int unsigned ElapsedW = 17;

  localparam logic signed [7:0]    ThresholdReset = -8'sd78;
  localparam logic [15:0]          HoldReset      = 16'd10;
  localparam logic [ElapsedW-1:0]  ElapsedMax     = {ElapsedW{1'b1}};

  typedef struct packed {
    logic [2:0]        kind;
    logic              beacon_found;
    logic signed [7:0] signal_strength;
    logic              switch_locked;
  } in_item_t;

  typedef struct packed {
    logic              relay_on;
    logic [1:0]        lock_status;
    logic [31:0]       open_total;
    logic signed [7:0] latest_strength;
  } out_item_t;

endpackage

// File: hdl/pdi_in_stage.sv
module pdi_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pdi_pkg::in_item_t in_item_i,
  input  logic             advance_i,
  output logic             valid_o,
  output pdi_pkg::in_item_t item_o
);
  import pdi_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  // Stage empties on advance, so a new transfer can land in the same cycle
  assign in_stall_o = valid_q & ~advance_i;
  assign take       = in_valid_i & ~in_stall_o;
  assign valid_d    = take | (valid_q & ~advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hdl/pdi_core.sv
module pdi_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pdi_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [pdi_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             upd_i,
  input  pdi_pkg::in_item_t                item_i,
  output pdi_pkg::out_item_t               result_o
);
  import pdi_pkg::*;

  logic signed [7:0]   thresh_q;
  logic [15:0]         hold_q;

  logic                door_q, door_d;
  lock_e               lock_q, lock_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [31:0]         count_q, count_d;
  logic signed [7:0]   strength_q, strength_d;

  logic                can_open;

  function automatic lock_e lock_add(lock_e cur, lock_e src);
    lock_e r;
    if (cur == LockNone) begin
      r = src;
    end else if (cur != src) begin
      r = LockBoth;
    end else begin
      r = cur;
    end
    return r;
  endfunction

  function automatic lock_e lock_drop(lock_e cur, lock_e src);
    lock_e r;
    if (cur == src) begin
      r = LockNone;
    end else if (cur == LockBoth) begin
      r = (src == LockSwitch) ? LockRemote : LockSwitch;
    end else begin
      r = cur;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThresholdReset;
      hold_q   <= HoldReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgThreshold: thresh_q <= cfg_data_i[7:0];
        CfgHold:      hold_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign can_open = ~door_q & (lock_q == LockNone);

  always_comb begin
    door_d     = door_q;
    lock_d     = lock_q;
    elapsed_d  = elapsed_q;
    count_d    = count_q;
    strength_d = strength_q;
    unique case (item_i.kind)
      KindScan: begin
        if (item_i.beacon_found) begin
          strength_d = item_i.signal_strength;
          if (item_i.signal_strength > thresh_q && can_open) begin
            door_d    = 1'b1;
            elapsed_d = '0;
            count_d   = count_q + 32'd1;
          end
        end
      end
      KindSwitch: begin
        if (item_i.switch_locked) begin
          door_d    = 1'b0;
          elapsed_d = '0;
          lock_d    = lock_add(lock_q, LockSwitch);
        end else begin
          lock_d = lock_drop(lock_q, LockSwitch);
          // auto close once the hold time has run out
          if (door_q && (elapsed_q > {1'b0, hold_q})) begin
            door_d    = 1'b0;
            elapsed_d = '0;
          end
        end
      end
      KindTick: begin
        if (door_q && (elapsed_q != ElapsedMax)) begin
          elapsed_d = elapsed_q + 1'b1;
        end
      end
      KindRemoteLock: begin
        lock_d    = lock_add(lock_q, LockRemote);
        door_d    = 1'b0;
        elapsed_d = '0;
      end
      KindRemoteUnlock: begin
        lock_d = lock_drop(lock_q, LockRemote);
      end
      KindRemoteOpen: begin
        if (can_open) begin
          door_d    = 1'b1;
          elapsed_d = '0;
          count_d   = count_q + 32'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      door_q     <= 1'b0;
      lock_q     <= LockNone;
      elapsed_q  <= '0;
      count_q    <= '0;
      strength_q <= '0;
    end else if (upd_i) begin
      door_q     <= door_d;
      lock_q     <= lock_d;
      elapsed_q  <= elapsed_d;
      count_q    <= count_d;
      strength_q <= strength_d;
    end
  end

  assign result_o.relay_on        = door_d;
  assign result_o.lock_status     = lock_d;
  assign result_o.open_total      = count_d;
  assign result_o.latest_strength = strength_d;

`ifndef ASSERT_OFF
  // any lock closes the door and no open happens while locked
  a_open_unlocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    door_q |-> (lock_q == LockNone))
    else $error("door open while locked");

  a_elapsed_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !door_q |-> (elapsed_q == '0))
    else $error("elapsed time nonzero with door closed");

  a_count_on_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($rose(door_q) && count_q == $past(count_q) + 32'd1))
    else $error("open count moved without an opening");

  a_no_update_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_i |=> $stable(door_q) && $stable(lock_q) && $stable(elapsed_q))
    else $error("state changed without an item");
`endif

endmodule

// File: hdl/pdi_out_stage.sv
module pdi_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  pdi_pkg::out_item_t result_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pdi_pkg::out_item_t out_item_o
);
  import pdi_pkg::*;

  logic      valid_q, valid_d;
  out_item_t res_q;

  // register can take a new result when empty or when its transfer completes now
  assign free_o  = ~valid_q | ~out_stall_i;
  assign valid_d = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = res_q;

endmodule

// File: hdl/proximity_door_interlock.sv
// Door interlock controller. Each input transfer is one event (scan result, lockout
// switch sample, one-second tick, remote lock/unlock/open) and yields exactly one
// output transfer reporting the door relay, lock source, opening count and last
// beacon strength after that event. An event sits in the input register, is
// evaluated combinationally against the controller state, and its result goes to
// the output register. One event per cycle is sustained while the output is not
// stalled. A stalled output holds its result; the next event then waits in the
// input register and a third one sees the input stall. The user must write
// threshold and hold time through the cfg port while no event is in flight; the
// block itself does not enforce this.
module proximity_door_interlock (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pdi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pdi_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  pdi_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pdi_pkg::out_item_t           out_item_o
);
  import pdi_pkg::*;

  logic      s0_valid;
  in_item_t  s0_item;
  logic      out_free;
  logic      advance;
  out_item_t result;

  assign advance = s0_valid & out_free;

  pdi_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .valid_o    (s0_valid),
    .item_o     (s0_item)
  );

  pdi_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .upd_i      (advance),
    .item_i     (s0_item),
    .result_o   (result)
  );

  pdi_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
